[src/pum_pkg.sv]
// shared types and codes for the posting union minus deletes unit
package pum_pkg;

    // operation codes carried in s_tuser
    localparam logic [2:0] OP_LOAD_ADD = 3'd0;
    localparam logic [2:0] OP_LOAD_DEL = 3'd1;
    localparam logic [2:0] OP_START    = 3'd2;
    localparam logic [2:0] OP_NEXT     = 3'd3;
    localparam logic [2:0] OP_SEEK     = 3'd4;

    // result status codes carried in m_tuser
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_FOUND = 2'd2;
    localparam logic [1:0] STAT_EXH   = 2'd3;

    // register indexes (word address bits)
    localparam logic [1:0] REG_LIST_MODE = 2'd0;
    localparam logic [1:0] REG_ADD_USED  = 2'd1;
    localparam logic [1:0] REG_DEL_USED  = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MIN_RD,
        S_MIN_CMP,
        S_DUP_RD,
        S_DUP_CMP,
        S_DEL_RD,
        S_DEL_CMP,
        S_SKA_RD,
        S_SKA_CMP,
        S_SKD_RD,
        S_SKD_CMP,
        S_OUT
    } pum_state_t;

endpackage

[src/pum_store.sv]
// list storage: add doc ids, add frequencies and delete doc ids
module pum_store import pum_pkg::*; #(
    parameter int NUM_ADD    = 4,
    parameter int NUM_DEL    = 4,
    parameter int LIST_DEPTH = 256,
    localparam int AAW = (NUM_ADD * LIST_DEPTH > 1) ? $clog2(NUM_ADD * LIST_DEPTH) : 1,
    localparam int DAW = (NUM_DEL * LIST_DEPTH > 1) ? $clog2(NUM_DEL * LIST_DEPTH) : 1
) (
    input  logic           aclk,
    input  logic           add_we,
    input  logic [AAW-1:0] add_waddr,
    input  logic [63:0]    add_wdoc,
    input  logic [31:0]    add_wfreq,
    input  logic [AAW-1:0] add_raddr,
    output logic [63:0]    add_rdoc,
    output logic [31:0]    add_rfreq,
    input  logic           del_we,
    input  logic [DAW-1:0] del_waddr,
    input  logic [63:0]    del_wdoc,
    input  logic [DAW-1:0] del_raddr,
    output logic [63:0]    del_rdoc
);

    logic [63:0] add_doc_mem  [NUM_ADD * LIST_DEPTH];
    logic [31:0] add_freq_mem [NUM_ADD * LIST_DEPTH];
    logic [63:0] del_doc_mem  [NUM_DEL * LIST_DEPTH];

    // add lists: one write, one registered read
    always_ff @(posedge aclk) begin
        if (add_we) begin
            add_doc_mem[add_waddr]  <= add_wdoc;
            add_freq_mem[add_waddr] <= add_wfreq;
        end
        add_rdoc  <= add_doc_mem[add_raddr];
        add_rfreq <= add_freq_mem[add_raddr];
    end

    // delete lists: one write, one registered read
    always_ff @(posedge aclk) begin
        if (del_we) begin
            del_doc_mem[del_waddr] <= del_wdoc;
        end
        del_rdoc <= del_doc_mem[del_raddr];
    end

endmodule

[src/posting_union_minus_deletes_unit.sv]
// top level: sorted merge of add lists minus delete lists, with apb configuration
// Each beat on s_ is one operation and yields exactly one result beat on m_. Loads,
// start and unused codes go from the accepting cycle straight to the state that loads
// the output register. Next and seek run a sequencer over one registered read port per
// list memory: a next scans the live add lists for the minimum, steps the other add
// cursors over duplicates of it and steps the delete cursors up to it, and repeats this
// for every deleted doc that is skipped; a seek first steps the live list cursors toward
// the target. A seek whose target is not above a valid current doc returns that doc with
// no walk. A new beat is taken once the previous result sits in the output register;
// a stalled result holds the sequencer. No clearing pass follows reset.
module posting_union_minus_deletes_unit import pum_pkg::*; #(
    parameter int NUM_ADD    = 4,
    parameter int NUM_DEL    = 4,
    parameter int LIST_DEPTH = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    // apb configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // operation beats
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,  // doc_key [63:0], term_freq [95:64]
    input  logic [4:0]   s_tuser,  // op [2:0], list_sel [4:3]
    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,  // doc_out [63:0], freq_out [95:64]
    output logic [1:0]   m_tuser   // status [1:0]
);

    localparam int AAW = (NUM_ADD * LIST_DEPTH > 1) ? $clog2(NUM_ADD * LIST_DEPTH) : 1;
    localparam int DAW = (NUM_DEL * LIST_DEPTH > 1) ? $clog2(NUM_DEL * LIST_DEPTH) : 1;
    localparam int CW  = $clog2(LIST_DEPTH + 1);
    localparam int PW  = $clog2(LIST_DEPTH);
    localparam int AIW = (NUM_ADD > 1) ? $clog2(NUM_ADD) : 1;
    localparam int DIW = (NUM_DEL > 1) ? $clog2(NUM_DEL) : 1;
    localparam int NAW = $clog2(NUM_ADD + 1);
    localparam int NDW = $clog2(NUM_DEL + 1);
    localparam int MAXN = (NUM_ADD > NUM_DEL) ? NUM_ADD : NUM_DEL;
    localparam int IW  = $clog2(MAXN + 1);

    pum_state_t state_reg, state_next;

    // configuration
    logic           mode_reg;
    logic [2:0]     add_used_reg, del_used_reg;
    logic [NAW-1:0] n_add;
    logic [NDW-1:0] n_del;

    // list bookkeeping
    logic [CW-1:0] add_len_reg [NUM_ADD];
    logic [CW-1:0] add_cur_reg [NUM_ADD];
    logic [CW-1:0] del_len_reg [NUM_DEL];
    logic [CW-1:0] del_cur_reg [NUM_DEL];

    // iteration state
    logic [IW-1:0]  idx_reg;
    logic [AIW-1:0] best_reg;
    logic           found_reg, deleted_reg;
    logic [63:0]    bd_reg, key_reg;
    logic [31:0]    bfreq_reg;
    logic [63:0]    cur_doc_reg;
    logic [31:0]    cur_freq_reg;
    logic           cur_valid_reg;

    // pending result and output register
    logic [1:0]  res_stat_reg;
    logic [63:0] res_doc_reg;
    logic [31:0] res_freq_reg;
    logic        m_valid_reg;
    logic [1:0]  m_stat_reg;
    logic [63:0] m_doc_reg;
    logic [31:0] m_freq_reg;

    // input fields
    logic [2:0]  in_op;
    logic [1:0]  in_sel;
    logic [63:0] in_key;
    logic [31:0] in_freq;
    logic        accept;
    logic [AIW-1:0] sel_a;
    logic [DIW-1:0] sel_d;
    logic        add_ok, del_ok;

    // memory ports
    logic           add_we, del_we;
    logic [AAW-1:0] add_waddr, add_raddr;
    logic [DAW-1:0] del_waddr, del_raddr;
    logic [63:0]    add_rdoc, del_rdoc;
    logic [31:0]    add_rfreq;

    // walk helpers
    logic [AIW-1:0] a_idx;
    logic [DIW-1:0] d_idx;
    logic           a_end, d_end, a_live, d_live;

    assign in_op   = s_tuser[2:0];
    assign in_sel  = s_tuser[4:3];
    assign in_key  = s_tdata[63:0];
    assign in_freq = s_tdata[95:64];
    assign accept  = s_tvalid && s_tready;
    assign sel_a   = AIW'(in_sel);
    assign sel_d   = DIW'(in_sel);
    assign add_ok  = (32'(in_sel) < NUM_ADD) && (32'(add_len_reg[sel_a]) < LIST_DEPTH);
    assign del_ok  = (32'(in_sel) < NUM_DEL) && (32'(del_len_reg[sel_d]) < LIST_DEPTH);

    // lists in use, saturated at what is built
    assign n_add = (32'(add_used_reg) > NUM_ADD) ? NAW'(NUM_ADD) : NAW'(add_used_reg);
    assign n_del = (32'(del_used_reg) > NUM_DEL) ? NDW'(NUM_DEL) : NDW'(del_used_reg);

    assign a_idx  = AIW'(idx_reg);
    assign d_idx  = DIW'(idx_reg);
    assign a_end  = 32'(idx_reg) >= 32'(n_add);
    assign d_end  = 32'(idx_reg) >= 32'(n_del);
    assign a_live = add_cur_reg[a_idx] < add_len_reg[a_idx];
    assign d_live = del_cur_reg[d_idx] < del_len_reg[d_idx];

    pum_store #(
        .NUM_ADD    (NUM_ADD),
        .NUM_DEL    (NUM_DEL),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_store (
        .aclk      (aclk),
        .add_we    (add_we),
        .add_waddr (add_waddr),
        .add_wdoc  (in_key),
        .add_wfreq (in_freq),
        .add_raddr (add_raddr),
        .add_rdoc  (add_rdoc),
        .add_rfreq (add_rfreq),
        .del_we    (del_we),
        .del_waddr (del_waddr),
        .del_wdoc  (in_key),
        .del_raddr (del_raddr),
        .del_rdoc  (del_rdoc)
    );

    // outputs of the sequencer: handshake, write enables and memory addresses
    always_comb begin
        s_tready  = (state_reg == S_IDLE);
        add_we    = accept && (in_op == OP_LOAD_ADD) && add_ok;
        del_we    = accept && (in_op == OP_LOAD_DEL) && del_ok;
        add_waddr = AAW'(32'(sel_a) * LIST_DEPTH + 32'(add_len_reg[sel_a][PW-1:0]));
        del_waddr = DAW'(32'(sel_d) * LIST_DEPTH + 32'(del_len_reg[sel_d][PW-1:0]));
        add_raddr = AAW'(32'(a_idx) * LIST_DEPTH + 32'(add_cur_reg[a_idx][PW-1:0]));
        del_raddr = DAW'(32'(d_idx) * LIST_DEPTH + 32'(del_cur_reg[d_idx][PW-1:0]));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (in_op)
                        OP_NEXT: state_next = S_MIN_RD;
                        OP_SEEK: begin
                            if (cur_valid_reg && cur_doc_reg >= in_key) begin
                                state_next = S_OUT;
                            end else begin
                                state_next = S_SKA_RD;
                            end
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_MIN_RD: begin
                if (a_end) begin
                    state_next = found_reg ? S_DUP_RD : S_OUT;
                end else if (a_live) begin
                    state_next = S_MIN_CMP;
                end
            end
            S_MIN_CMP: state_next = S_MIN_RD;
            S_DUP_RD: begin
                if (a_end) begin
                    state_next = S_DEL_RD;
                end else if (a_idx != best_reg && a_live) begin
                    state_next = S_DUP_CMP;
                end
            end
            S_DUP_CMP: state_next = S_DUP_RD;
            S_DEL_RD: begin
                if (d_end) begin
                    state_next = deleted_reg ? S_MIN_RD : S_OUT;
                end else if (d_live) begin
                    state_next = S_DEL_CMP;
                end
            end
            S_DEL_CMP: state_next = S_DEL_RD;
            S_SKA_RD: begin
                if (a_end) begin
                    state_next = S_SKD_RD;
                end else if (a_live) begin
                    state_next = S_SKA_CMP;
                end
            end
            S_SKA_CMP: state_next = S_SKA_RD;
            S_SKD_RD: begin
                if (d_end) begin
                    state_next = S_MIN_RD;
                end else if (d_live) begin
                    state_next = S_SKD_CMP;
                end
            end
            S_SKD_CMP: state_next = S_SKD_RD;
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath: list bookkeeping, walk registers and results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ADD; i++) begin
                add_len_reg[i] <= '0;
                add_cur_reg[i] <= '0;
            end
            for (int j = 0; j < NUM_DEL; j++) begin
                del_len_reg[j] <= '0;
                del_cur_reg[j] <= '0;
            end
            cur_valid_reg <= 1'b0;
            cur_doc_reg   <= '0;
            cur_freq_reg  <= '0;
            m_valid_reg   <= 1'b0;
            mode_reg      <= 1'b0;
            add_used_reg  <= 3'd1;
            del_used_reg  <= 3'd0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            deleted_reg   <= 1'b0;
        end else begin
            // register writes
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    REG_LIST_MODE: mode_reg     <= pwdata[0];
                    REG_ADD_USED:  add_used_reg <= pwdata[2:0];
                    REG_DEL_USED:  del_used_reg <= pwdata[2:0];
                    default: ;
                endcase
            end

            // result beat taken with nothing new to load
            if (m_valid_reg && m_tready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        res_doc_reg  <= '0;
                        res_freq_reg <= '0;
                        idx_reg      <= '0;
                        found_reg    <= 1'b0;
                        key_reg      <= in_key;
                        case (in_op)
                            OP_LOAD_ADD: begin
                                if (add_ok) begin
                                    add_len_reg[sel_a] <= add_len_reg[sel_a] + 1'b1;
                                    res_stat_reg <= STAT_OK;
                                end else begin
                                    res_stat_reg <= STAT_FULL;
                                end
                            end
                            OP_LOAD_DEL: begin
                                if (del_ok) begin
                                    del_len_reg[sel_d] <= del_len_reg[sel_d] + 1'b1;
                                    res_stat_reg <= STAT_OK;
                                end else begin
                                    res_stat_reg <= STAT_FULL;
                                end
                            end
                            OP_START: begin
                                for (int i = 0; i < NUM_ADD; i++) add_cur_reg[i] <= '0;
                                for (int j = 0; j < NUM_DEL; j++) del_cur_reg[j] <= '0;
                                cur_valid_reg <= 1'b0;
                                cur_doc_reg   <= '0;
                                cur_freq_reg  <= '0;
                                res_stat_reg  <= STAT_OK;
                            end
                            OP_SEEK: begin
                                // current doc already at or past the target
                                res_stat_reg <= STAT_FOUND;
                                res_doc_reg  <= cur_doc_reg;
                                res_freq_reg <= cur_freq_reg;
                            end
                            default: res_stat_reg <= STAT_OK;
                        endcase
                    end
                end
                S_MIN_RD: begin
                    if (a_end) begin
                        idx_reg <= '0;
                        if (found_reg) begin
                            add_cur_reg[best_reg] <= add_cur_reg[best_reg] + 1'b1;
                        end else begin
                            cur_valid_reg <= 1'b0;
                            res_stat_reg  <= STAT_EXH;
                            res_doc_reg   <= '0;
                            res_freq_reg  <= '0;
                        end
                    end else if (!a_live) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_MIN_CMP: begin
                    // keep the lowest list on ties
                    if (!found_reg || add_rdoc < bd_reg) begin
                        found_reg <= 1'b1;
                        best_reg  <= a_idx;
                        bd_reg    <= add_rdoc;
                        bfreq_reg <= add_rfreq;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                S_DUP_RD: begin
                    if (a_end) begin
                        idx_reg     <= '0;
                        deleted_reg <= 1'b0;
                    end else if (a_idx == best_reg || !a_live) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DUP_CMP: begin
                    if (add_rdoc == bd_reg) begin
                        add_cur_reg[a_idx] <= add_cur_reg[a_idx] + 1'b1;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DEL_RD: begin
                    if (d_end) begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        if (!deleted_reg) begin
                            cur_valid_reg <= 1'b1;
                            cur_doc_reg   <= bd_reg;
                            cur_freq_reg  <= mode_reg ? bfreq_reg : 32'd0;
                            res_stat_reg  <= STAT_FOUND;
                            res_doc_reg   <= bd_reg;
                            res_freq_reg  <= mode_reg ? bfreq_reg : 32'd0;
                        end
                    end else if (!d_live) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DEL_CMP: begin
                    // delete cursor stops at the first id not below the candidate
                    if (del_rdoc < bd_reg) begin
                        del_cur_reg[d_idx] <= del_cur_reg[d_idx] + 1'b1;
                    end else begin
                        if (del_rdoc == bd_reg) begin
                            deleted_reg <= 1'b1;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SKA_RD: begin
                    if (a_end) begin
                        idx_reg <= '0;
                    end else if (!a_live) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SKA_CMP: begin
                    if (add_rdoc < key_reg) begin
                        add_cur_reg[a_idx] <= add_cur_reg[a_idx] + 1'b1;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SKD_RD: begin
                    if (d_end) begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                    end else if (!d_live) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SKD_CMP: begin
                    if (del_rdoc < key_reg) begin
                        del_cur_reg[d_idx] <= del_cur_reg[d_idx] + 1'b1;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_stat_reg  <= res_stat_reg;
                        m_doc_reg   <= res_doc_reg;
                        m_freq_reg  <= res_freq_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[3:2])
            REG_LIST_MODE: prdata = {31'd0, mode_reg};
            REG_ADD_USED:  prdata = {29'd0, add_used_reg};
            REG_DEL_USED:  prdata = {29'd0, del_used_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_freq_reg, m_doc_reg};
    assign m_tuser  = m_stat_reg;

endmodule

[src/pum_checker.sv]
// port-level checks for the posting union minus deletes unit, with bind
module pum_checker import pum_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // only a found result carries a doc or a frequency
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STAT_FOUND |-> m_tdata == 96'd0)
        else $error("non-found result with nonzero payload");

    // an accepted beat is followed by a busy input side
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken before a result was formed");

    // a result beat rises only out of a beat in work, never from an idle input side
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a beat in work");

endmodule

bind posting_union_minus_deletes_unit pum_checker u_pum_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[dv/tb.sv]
// testbench for the posting union minus deletes unit: random and directed beats with a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pum_pkg::*;

    localparam int NA = 4;
    localparam int ND = 4;
    localparam int DEPTH = 256;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] doc;
        logic [31:0] freq;
    } pum_result_t;

    // merge predictor plus queue of expected results
    class merge_scoreboard;
        logic [63:0] add_doc [NA][DEPTH];
        logic [31:0] add_freq [NA][DEPTH];
        logic [63:0] del_doc [ND][DEPTH];
        int add_len [NA];
        int del_len [ND];
        int add_cur [NA];
        int del_cur [ND];
        logic [63:0] cur_doc;
        logic [31:0] cur_freq;
        bit cur_valid;
        bit weighted;
        int adds_used;
        int dels_used;
        pum_result_t pending_results[$];
        int errors;
        int ops_seen;

        function void clear();
            for (int i = 0; i < NA; i++) begin
                add_len[i] = 0;
                add_cur[i] = 0;
            end
            for (int j = 0; j < ND; j++) begin
                del_len[j] = 0;
                del_cur[j] = 0;
            end
            cur_doc = '0;
            cur_freq = '0;
            cur_valid = 0;
            weighted = 0;
            adds_used = 1;
            dels_used = 0;
            errors = 0;
            ops_seen = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == REG_LIST_MODE) weighted = val[0];
            else if (idx == REG_ADD_USED) adds_used = (val[2:0] > NA) ? NA : val[2:0];
            else if (idx == REG_DEL_USED) dels_used = (val[2:0] > ND) ? ND : val[2:0];
        endfunction

        function void dels_forward(logic [63:0] target);
            for (int j = 0; j < dels_used; j++)
                while (del_cur[j] < del_len[j] && del_doc[j][del_cur[j]] < target)
                    del_cur[j]++;
        endfunction

        function pum_result_t merge_next();
            pum_result_t r;
            bit found;
            bit deleted;
            int best;
            logic [63:0] bd;
            logic [31:0] fr;
            forever begin
                found = 0;
                best = 0;
                bd = '0;
                for (int i = 0; i < adds_used; i++)
                    if (add_cur[i] < add_len[i] && (!found || add_doc[i][add_cur[i]] < bd)) begin
                        found = 1;
                        best = i;
                        bd = add_doc[i][add_cur[i]];
                    end
                if (!found) begin
                    cur_valid = 0;
                    r = '{STAT_EXH, '0, '0};
                    return r;
                end
                fr = weighted ? add_freq[best][add_cur[best]] : '0;
                for (int i = 0; i < adds_used; i++)
                    if (i != best)
                        while (add_cur[i] < add_len[i] && add_doc[i][add_cur[i]] == bd)
                            add_cur[i]++;
                add_cur[best]++;
                dels_forward(bd);
                deleted = 0;
                for (int j = 0; j < dels_used; j++)
                    if (del_cur[j] < del_len[j] && del_doc[j][del_cur[j]] == bd) deleted = 1;
                if (!deleted) begin
                    cur_valid = 1;
                    cur_doc = bd;
                    cur_freq = fr;
                    r = '{STAT_FOUND, bd, fr};
                    return r;
                end
            end
        endfunction

        // note an accepted operation beat
        function void note_op(logic [2:0] op, logic [1:0] sel, logic [63:0] key,
                              logic [31:0] tf);
            pum_result_t r;
            r = '{STAT_OK, '0, '0};
            ops_seen++;
            case (op)
                OP_LOAD_ADD: begin
                    if (add_len[sel] >= DEPTH) r.status = STAT_FULL;
                    else begin
                        add_doc[sel][add_len[sel]] = key;
                        add_freq[sel][add_len[sel]] = tf;
                        add_len[sel]++;
                    end
                end
                OP_LOAD_DEL: begin
                    if (del_len[sel] >= DEPTH) r.status = STAT_FULL;
                    else begin
                        del_doc[sel][del_len[sel]] = key;
                        del_len[sel]++;
                    end
                end
                OP_START: begin
                    for (int i = 0; i < NA; i++) add_cur[i] = 0;
                    for (int j = 0; j < ND; j++) del_cur[j] = 0;
                    cur_doc = '0;
                    cur_freq = '0;
                    cur_valid = 0;
                end
                OP_NEXT: r = merge_next();
                OP_SEEK: begin
                    if (cur_valid && cur_doc >= key) r = '{STAT_FOUND, cur_doc, cur_freq};
                    else begin
                        for (int i = 0; i < adds_used; i++)
                            while (add_cur[i] < add_len[i] && add_doc[i][add_cur[i]] < key)
                                add_cur[i]++;
                        dels_forward(key);
                        r = merge_next();
                    end
                end
                default: ;
            endcase
            pending_results.insert(pending_results.size(), r);
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(logic [1:0] st, logic [63:0] doc, logic [31:0] fr);
            pum_result_t e;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status %0d doc %h freq %h", $time, st, doc, fr);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (doc !== e.doc) begin
                $display("%0t: doc_out expected %h actual %h", $time, e.doc, doc);
                errors++;
            end
            if (fr !== e.freq) begin
                $display("%0t: freq_out expected %h actual %h", $time, e.freq, fr);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_tvalid = 0;
    logic s_tready;
    logic [95:0] s_tdata = '0;  // doc_key [63:0], term_freq [95:64]
    logic [4:0] s_tuser = '0;   // op [2:0], list_sel [4:3]
    logic m_tvalid;
    logic m_tready = 0;
    logic [95:0] m_tdata;       // doc_out [63:0], freq_out [95:64]
    logic [1:0] m_tuser;        // status [1:0]

    merge_scoreboard sb;
    bit idling = 1;
    // small key space so merges hit duplicates and deletes
    logic [63:0] key_base;

    posting_union_minus_deletes_unit dut (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    // result side: random stall bursts while idling is set, check on every accepted beat
    initial begin
        int stall;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata[63:0],
                                                                 m_tdata[95:64]);
            if (idling && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 16);
                m_tready <= 0;
                repeat (stall) begin
                    @(posedge aclk);
                    if (aresetn && m_tvalid && m_tready)
                        sb.check_result(m_tuser, m_tdata[63:0], m_tdata[95:64]);
                end
            end
            m_tready <= 1;
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.write_reg(idx, val);
    endtask

    // one operation beat, with an optional gap before it
    task automatic send_op(logic [2:0] op, logic [1:0] sel, logic [63:0] key,
                           logic [31:0] tf);
        if (idling && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= {sel, op};
        s_tdata <= {tf, key};
        do @(posedge aclk); while (!s_tready);
        sb.note_op(op, sel, key, tf);
    endtask

    task automatic wait_idle();
        s_tvalid <= 0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand_key();
        return key_base + $urandom_range(0, 63);
    endfunction

    function automatic logic [63:0] wide_rand();
        return {$urandom(), $urandom()};
    endfunction

    // fill lists with non-decreasing keys, then iterate with next and seek, mixed with add loads and unused codes
    task automatic merge_round(int nadd, int ndel);
        logic [63:0] k;
        logic [63:0] seek_key;
        for (int i = 0; i < nadd; i++) begin
            k = key_base;
            repeat ($urandom_range(0, 12)) begin
                k += $urandom_range(0, 3);
                send_op(OP_LOAD_ADD, 2'(i), k, $urandom());
            end
        end
        for (int j = 0; j < ndel; j++) begin
            k = key_base;
            repeat ($urandom_range(0, 6)) begin
                k += $urandom_range(0, 5);
                send_op(OP_LOAD_DEL, 2'(j), k, $urandom());
            end
        end
        send_op(OP_START, 2'($urandom()), wide_rand(), $urandom());
        seek_key = key_base;
        repeat ($urandom_range(5, 25)) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    seek_key += $urandom_range(0, 6);
                    send_op(OP_SEEK, 2'($urandom()), seek_key, $urandom());
                end
                2: send_op(OP_LOAD_ADD, 2'($urandom()), rand_key(), $urandom());
                3: send_op(3'($urandom_range(5, 7)), 2'($urandom()), wide_rand(), $urandom());
                default: send_op(OP_NEXT, 2'($urandom()), wide_rand(), $urandom());
            endcase
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty lists, extremes, unused codes, full list
        key_base = 64'd0;
        send_op(OP_NEXT, 0, '0, '0);
        send_op(OP_SEEK, 0, '1, '0);
        send_op(OP_LOAD_ADD, 0, 64'd0, 32'hFFFF_FFFF);
        send_op(OP_LOAD_ADD, 0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_op(OP_LOAD_DEL, 3, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        send_op(OP_START, 3, '0, '0);
        send_op(OP_NEXT, 0, '0, '0);
        send_op(OP_SEEK, 0, '0, '0);
        send_op(OP_NEXT, 0, '0, '0);
        send_op(OP_NEXT, 0, '0, '0);
        send_op(3'd5, 3, '1, '1);
        send_op(3'd6, 1, '0, '0);
        send_op(3'd7, 2, '1, '0);
        send_op(OP_LOAD_ADD, 0, 64'd5, 32'd7);
        send_op(OP_NEXT, 0, '0, '0);
        wait_idle();
        apb_write(REG_LIST_MODE, 32'd1);
        apb_write(REG_ADD_USED, 32'd7);
        apb_write(REG_DEL_USED, 32'd7);
        send_op(OP_START, 0, '0, '0);
        send_op(OP_SEEK, 0, 64'd1, '0);
        send_op(OP_NEXT, 0, '0, '0);
        // fill list 3 to the top and past it
        for (int i = 0; i <= DEPTH; i++) send_op(OP_LOAD_DEL, 3, '1, '0);
        for (int i = 0; i <= DEPTH; i++) send_op(OP_LOAD_ADD, 3, wide_rand(), $urandom());
        wait_idle();

        // random phases, each with a new key base and no reset; the lists keep earlier loads
        while (sb.ops_seen < 900) begin
            key_base = wide_rand() & ~64'hFF;
            if ($urandom_range(0, 3) == 0) key_base = '1 - 64'd200;
            apb_write(REG_LIST_MODE, $urandom_range(0, 1));
            apb_write(REG_ADD_USED, $urandom_range(0, 7));
            apb_write(REG_DEL_USED, $urandom_range(0, 7));
            if (sb.ops_seen > 750) idling = 0;
            // list 3 is full; lists 0..2 grow slowly over the run
            merge_round($urandom_range(1, 3), $urandom_range(0, 3));
            wait_idle();
        end
        wait_idle();
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
